FILE: src/mep_pkg.sv
// Shared constants, register codes and status types for the Mandelbrot pixel engine.
// Used by every module of the block; depends on nothing.
package mep_pkg;

	localparam int FRAC_BITS_DEF = 28;
	localparam int REG_FRAC      = 28;

	localparam int PIX_W    = 10;
	localparam int ITER_W   = 16;
	localparam int SHADE_W  = 8;
	localparam int ORG_W    = 32;
	localparam int STEP_W   = 31;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 48;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [1:0] REG_ORIGIN_RE = 2'd0;
	localparam logic [1:0] REG_ORIGIN_IM = 2'd1;
	localparam logic [1:0] REG_STEP      = 2'd2;
	localparam logic [1:0] REG_MAX_ITER  = 2'd3;

	localparam logic [ORG_W-1:0]  ORIGIN_RE_RST = 32'hDE00_0000;
	localparam logic [ORG_W-1:0]  ORIGIN_IM_RST = 32'hE800_0000;
	localparam logic [STEP_W-1:0] STEP_RST      = 31'd1006633;
	localparam logic [ITER_W-1:0] MAX_ITER_RST  = 16'd1024;

	typedef struct packed {
		logic              done;
		logic [ITER_W-1:0] iters;
	} iter_stat_t;

	typedef struct packed {
		logic               done;
		logic [SHADE_W-1:0] shade;
	} shade_stat_t;

endpackage

FILE: src/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel engine, top level.
// Input stream: s_tdata carries a pixel row and column; one word is taken when s_tvalid and
// s_tready are both high. Output stream: m_tdata carries row, column, iteration count and grey
// shade; one word leaves when m_tvalid and m_tready are both high. The APB port holds the
// image origin (real, imaginary), the pixel step and the iteration limit; pready is always high.
// One pixel is in flight at a time and s_tready is low while it is worked on.
// After a word is accepted, c is formed, then escape tests run (iterations + 1 for a point
// that escapes, max_iter for one that does not, none for a zero limit), and then the shade
// is computed before the word is loaded into the output register.
// Each iteration sends a*a, b*b and 2*a*b in turn through one registered multiplier; the
// shade comes from a bit-serial divider.
// The output register holds a finished word while the receiver stalls; the next pixel is taken
// as soon as that word sits in the output register, even if it has not been taken yet.
// Reset (arst_n low) clears the sequencers and the output valid, and loads the registers with
// the default view: origin -2.125 - 1.5i, step about 3.84/1024, limit 1024.
// Configuration writes are taken at any time but belong in idle periods.
module mandelbrot_escape_pixel #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mep_pkg::S_DATA_W-1:0]  s_tdata,   // row[9:0], col[19:10], zero[23:20]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mep_pkg::M_DATA_W-1:0]  m_tdata,   // out_row[9:0], out_col[19:10],
	                                                 // iterations[35:20], shade[43:36], zero[47:44]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mep_pkg::APB_AW-1:0]    paddr,
	input  logic [mep_pkg::APB_DW-1:0]    pwdata,
	output logic [mep_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int PW = mep_pkg::PIX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ITER = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                          state_q;
	logic                                m_tvalid_q;
	logic [mep_pkg::M_DATA_W-1:0]        m_tdata_q;
	logic [PW-1:0]                       row_q;
	logic [PW-1:0]                       col_q;
	logic [mep_pkg::ORG_W-1:0]           origin_re_q;
	logic [mep_pkg::ORG_W-1:0]           origin_im_q;
	logic [mep_pkg::STEP_W-1:0]          step_q;
	logic [mep_pkg::ITER_W-1:0]          max_iter_q;

	logic                                in_acc;
	logic                                cfg_wr;
	logic                                load;
	logic                                shade_go;
	mep_pkg::iter_stat_t                 iter_stat;
	mep_pkg::shade_stat_t                shade_stat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign shade_go = (state_q == ST_ITER) && iter_stat.done;
	assign load     = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= mep_pkg::ORIGIN_RE_RST;
			origin_im_q <= mep_pkg::ORIGIN_IM_RST;
			step_q      <= mep_pkg::STEP_RST;
			max_iter_q  <= mep_pkg::MAX_ITER_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mep_pkg::REG_ORIGIN_RE: origin_re_q <= pwdata;
				mep_pkg::REG_ORIGIN_IM: origin_im_q <= pwdata;
				mep_pkg::REG_STEP:      step_q      <= pwdata[mep_pkg::STEP_W-1:0];
				mep_pkg::REG_MAX_ITER:  max_iter_q  <= pwdata[mep_pkg::ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mep_pkg::REG_ORIGIN_RE: prdata = origin_re_q;
			mep_pkg::REG_ORIGIN_IM: prdata = origin_im_q;
			mep_pkg::REG_STEP:      prdata = {1'b0, step_q};
			mep_pkg::REG_MAX_ITER:  prdata = {{(mep_pkg::APB_DW - mep_pkg::ITER_W){1'b0}},
				max_iter_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new word replaces a taken one in the same cycle
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (iter_stat.done) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (shade_stat.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold the finished word until the output register frees up
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q <= s_tdata[PW-1:0];
			col_q <= s_tdata[2*PW-1:PW];
		end
		if (load) begin
			m_tdata_q <= {{(mep_pkg::M_DATA_W - 2*PW - mep_pkg::ITER_W - mep_pkg::SHADE_W){1'b0}},
				shade_stat.shade, iter_stat.iters, col_q, row_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	mep_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc),
		.row       (s_tdata[PW-1:0]),
		.col       (s_tdata[2*PW-1:PW]),
		.origin_re (origin_re_q),
		.origin_im (origin_im_q),
		.step      (step_q),
		.max_iter  (max_iter_q),
		.stat      (iter_stat)
	);

	mep_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (shade_go),
		.iters    (iter_stat.iters),
		.max_iter (max_iter_q),
		.stat     (shade_stat)
	);

endmodule

FILE: src/mep_mul.sv
// Shared fixed-point multiplier: sign-magnitude product, floor shift and saturation.
// Two register stages; uses mep_pkg for the default fraction width.
module mep_mul #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF,
	localparam int W = FRAC_BITS + 6
) (
	input  logic                clk,
	input  logic signed [W-1:0] x,
	input  logic signed [W-1:0] y,
	input  logic                dbl,
	output logic signed [W-1:0] res
);

	localparam int PW = 2 * W + 1;
	localparam int QB = PW - FRAC_BITS;
	localparam logic [PW-1:0] RND_C = {{(PW - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic [QB-1:0] LIM_Q = {{(QB - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};
	localparam logic [QB-1:0] MAX_Q = LIM_Q - QB'(1);
	localparam logic signed [W-1:0] W_MAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] W_MIN = {1'b1, {(W - 1){1'b0}}};

	logic [W-1:0]          ux;
	logic [W-1:0]          uy;
	logic [2*W-1:0]        prod_s1;
	logic                  neg_s1;
	logic                  dbl_s1;
	logic [PW-1:0]         pw;
	logic [PW-1:0]         rnd;
	logic [QB-1:0]         q;
	logic signed [W-1:0]   res_d;
	logic signed [W-1:0]   res_s2;

	assign ux = x[W-1] ? $unsigned(-x) : $unsigned(x);
	assign uy = y[W-1] ? $unsigned(-y) : $unsigned(y);

	always_ff @(posedge clk) begin
		prod_s1 <= ux * uy;
		neg_s1  <= x[W-1] ^ y[W-1];
		dbl_s1  <= dbl;
	end

	// Negative results round toward minus infinity: bias the magnitude up before the shift.
	always_comb begin
		pw  = dbl_s1 ? {prod_s1, 1'b0} : {1'b0, prod_s1};
		rnd = neg_s1 ? pw + RND_C : pw;
		q   = rnd[PW-1:FRAC_BITS];
		if (neg_s1) begin
			res_d = (q > LIM_Q) ? W_MIN : $signed(~q[W-1:0] + W'(1));
		end else begin
			res_d = (q > MAX_Q) ? W_MAX : $signed(q[W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

	assign res = res_s2;

endmodule

FILE: src/mep_iter.sv
// Escape-time sequencer: forms c from the pixel, then runs z = z*z + c on one shared multiplier.
// Instantiates mep_mul; uses mep_pkg for widths and the status struct.
module mep_iter #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [mep_pkg::PIX_W-1:0]          row,
	input  logic [mep_pkg::PIX_W-1:0]          col,
	input  logic [mep_pkg::ORG_W-1:0]          origin_re,
	input  logic [mep_pkg::ORG_W-1:0]          origin_im,
	input  logic [mep_pkg::STEP_W-1:0]         step,
	input  logic [mep_pkg::ITER_W-1:0]         max_iter,
	output mep_pkg::iter_stat_t                stat
);

	localparam int W   = FRAC_BITS + 6;
	localparam int SHL = (FRAC_BITS > mep_pkg::REG_FRAC) ? FRAC_BITS - mep_pkg::REG_FRAC : 0;
	localparam int SHR = (FRAC_BITS < mep_pkg::REG_FRAC) ? mep_pkg::REG_FRAC - FRAC_BITS : 0;
	localparam int SW  = 43;
	localparam int QW  = SW + SHL;
	localparam int PRW = mep_pkg::STEP_W + mep_pkg::PIX_W;

	localparam logic signed [W-1:0]  W_MAX  = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0]  W_MIN  = {1'b1, {(W - 1){1'b0}}};
	localparam logic signed [W+1:0]  W2_MAX = {3'b000, {(W - 1){1'b1}}};
	localparam logic signed [W+1:0]  W2_MIN = {3'b111, {(W - 1){1'b0}}};
	localparam logic signed [QW-1:0] Q_MAX  = {{(QW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN  = {{(QW - W + 1){1'b1}}, {(W - 1){1'b0}}};
	localparam logic signed [W:0]    FOUR   = {{(W - FRAC_BITS - 2){1'b0}}, 1'b1,
		{(FRAC_BITS + 2){1'b0}}};

	localparam logic [2:0] IT_IDLE  = 3'd0;
	localparam logic [2:0] IT_SETRE = 3'd1;
	localparam logic [2:0] IT_SETIM = 3'd2;
	localparam logic [2:0] IT_M0    = 3'd3;
	localparam logic [2:0] IT_M1    = 3'd4;
	localparam logic [2:0] IT_M2    = 3'd5;
	localparam logic [2:0] IT_M3    = 3'd6;
	localparam logic [2:0] IT_UPD   = 3'd7;

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
		if (v > W2_MAX) return W_MAX;
		if (v < W2_MIN) return W_MIN;
		return v[W-1:0];
	endfunction

	logic [2:0]                  state_q;
	logic                        done_q;
	logic [mep_pkg::ITER_W-1:0]  iters_q;
	logic [mep_pkg::PIX_W-1:0]   row_q;
	logic [mep_pkg::PIX_W-1:0]   col_q;
	logic signed [W-1:0]         a_q;
	logic signed [W-1:0]         b_q;
	logic signed [W-1:0]         cr_q;
	logic signed [W-1:0]         ci_q;
	logic signed [W-1:0]         a2_q;
	logic signed [W-1:0]         b2_q;
	logic [mep_pkg::ITER_W-1:0]  k_q;

	logic [mep_pkg::PIX_W-1:0]   idx;
	logic [mep_pkg::ORG_W-1:0]   org;
	logic [PRW-1:0]              prod;
	logic signed [SW-1:0]        sum;
	logic signed [QW-1:0]        qs;
	logic signed [W-1:0]         cvt;
	logic signed [W-1:0]         mx;
	logic signed [W-1:0]         my;
	logic                        mdbl;
	logic signed [W-1:0]         mres;
	logic signed [W:0]           mag2;
	logic                        esc;
	logic [mep_pkg::ITER_W:0]    k_nx;
	logic                        last;
	logic signed [W+1:0]         a_sum;
	logic signed [W+1:0]         b_sum;

	// Point c: origin + step*index in Q4.28, rescaled to the working format and saturated.
	always_comb begin
		idx  = (state_q == IT_SETRE) ? col_q : row_q;
		org  = (state_q == IT_SETRE) ? origin_re : origin_im;
		prod = step * idx;
		sum  = SW'($signed(org)) + $signed({2'b00, prod});
		qs   = (QW'(sum) <<< SHL) >>> SHR;
		if (qs > Q_MAX) begin
			cvt = W_MAX;
		end else if (qs < Q_MIN) begin
			cvt = W_MIN;
		end else begin
			cvt = qs[W-1:0];
		end
	end

	// Issue a*a, b*b, then 2a*b on consecutive cycles.
	assign mx   = (state_q == IT_M1) ? b_q : a_q;
	assign my   = (state_q == IT_M0) ? a_q : b_q;
	assign mdbl = (state_q == IT_M2);

	mep_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk),
		.x   (mx),
		.y   (my),
		.dbl (mdbl),
		.res (mres)
	);

	assign mag2  = (W+1)'(a2_q) + (W+1)'(mres);
	assign esc   = (mag2 > FOUR);
	assign k_nx  = {1'b0, k_q} + (mep_pkg::ITER_W+1)'(1);
	assign last  = (k_nx == {1'b0, max_iter});
	assign a_sum = (W+2)'(a2_q) - (W+2)'(b2_q) + (W+2)'(cr_q);
	assign b_sum = (W+2)'(mres) + (W+2)'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
			done_q  <= 1'b0;
		end else begin
			// pulse done for one cycle when the count is final
			done_q <= ((state_q == IT_SETIM) && (max_iter == '0))
				|| ((state_q == IT_M3) && (esc || last));
			case (state_q)
				IT_IDLE: begin
					if (start) state_q <= IT_SETRE;
				end
				IT_SETRE: state_q <= IT_SETIM;
				IT_SETIM: begin
					if (max_iter == '0) begin
						state_q <= IT_IDLE;
					end else begin
						state_q <= IT_M0;
					end
				end
				IT_M0: state_q <= IT_M1;
				IT_M1: state_q <= IT_M2;
				IT_M2: state_q <= IT_M3;
				IT_M3: begin
					if (esc || last) begin
						state_q <= IT_IDLE;
					end else begin
						state_q <= IT_UPD;
					end
				end
				IT_UPD: state_q <= IT_M0;
				default: state_q <= IT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IT_IDLE: begin
				if (start) begin
					row_q <= row;
					col_q <= col;
				end
			end
			IT_SETRE: begin
				cr_q <= cvt;
				a_q  <= cvt;
			end
			IT_SETIM: begin
				ci_q    <= cvt;
				b_q     <= cvt;
				k_q     <= '0;
				iters_q <= '0;
			end
			IT_M2: a2_q <= mres;
			IT_M3: begin
				b2_q <= mres;
				if (esc) begin
					iters_q <= k_q;
				end else begin
					iters_q <= k_nx[mep_pkg::ITER_W-1:0];
				end
			end
			IT_UPD: begin
				a_q <= sat_w(a_sum);
				b_q <= sat_w(b_sum);
				k_q <= k_nx[mep_pkg::ITER_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign stat.done  = done_q;
	assign stat.iters = iters_q;

endmodule

FILE: src/mep_shade.sv
// Shade divider: 255 - floor(iters*255/max_iter), or 255 for a zero limit, one quotient bit per cycle.
// Uses mep_pkg for widths and the status struct.
module mep_shade (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mep_pkg::ITER_W-1:0]  iters,
	input  logic [mep_pkg::ITER_W-1:0]  max_iter,
	output mep_pkg::shade_stat_t        stat
);

	localparam int IW = mep_pkg::ITER_W;
	localparam int SW = mep_pkg::SHADE_W;
	localparam int NW = IW + SW;

	logic              busy_q;
	logic              done_q;
	logic [2:0]        cnt_q;
	logic [IW-1:0]     rem_q;
	logic [SW-1:0]     low_q;
	logic [SW-1:0]     quo_q;
	logic [SW-1:0]     shade_q;
	logic [NW-1:0]     num;
	logic [IW:0]       t;
	logic              ge;
	logic [IW:0]       diff;
	logic [SW-1:0]     quo_nx;

	// iters*255 as (iters << 8) - iters; the top bits start below max_iter since iters <= max_iter
	assign num    = {iters, {SW{1'b0}}} - NW'(iters);
	assign t      = {rem_q, low_q[SW-1]};
	assign ge     = (t >= {1'b0, max_iter});
	assign diff   = t - {1'b0, max_iter};
	assign quo_nx = {quo_q[SW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 3'd7);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NW-1:SW];
			low_q <= num[SW-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[IW-1:0] : t[IW-1:0];
			low_q <= {low_q[SW-2:0], 1'b0};
			quo_q <= quo_nx;
			if (cnt_q == 3'd7) begin
				// zero limit runs no iteration and shows full white
				shade_q <= (max_iter == '0) ? {SW{1'b1}} : ~quo_nx;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.shade = shade_q;

endmodule

FILE: src/mep_checker.sv
// Port-level checks for the Mandelbrot pixel engine, bound to the top level.
// Sees only the top-level ports; uses mep_pkg for port widths.
module mep_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mep_pkg::M_DATA_W-1:0]  m_tdata
);

	// one pixel at a time: no second word right after a taken one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a pixel is in flight");

	// a result never appears right behind the word that caused it
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##1 !$rose(m_tvalid))
		else $error("result appeared too soon after an input word");

	// zero iterations always come with full white
	a_zero_white: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[35:20] == 16'd0)) |-> (m_tdata[43:36] == 8'hFF))
		else $error("zero iterations without white shade");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output word changed or dropped");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);
